@@ sv/utf8d_pkg.sv @@
// Shared types, constants and byte helpers for the UTF-8 stream decoder.
package utf8d_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int USED_W      = 3;
    localparam int MAX_RESULTS = 3;
    localparam int HELD_DEPTH  = 3;
    localparam int CNT_W       = 2;
    localparam int LEN_W       = 3;
    localparam int BUF_W       = 4 * BYTE_W;

    // Lead byte classes
    localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_LEAD2  = 8'hE0;
    localparam logic [BYTE_W-1:0] PAT_LEAD2   = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3  = 8'hF0;
    localparam logic [BYTE_W-1:0] PAT_LEAD3   = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4  = 8'hF8;
    localparam logic [BYTE_W-1:0] PAT_LEAD4   = 8'hF0;

    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0]   codepoint;
        logic [USED_W-1:0] bytes_used;
        logic              string_end;
    } result_t;

    // Everything one byte produces: results plus the next hold state
    typedef struct packed {
        logic [CNT_W-1:0]                  count;
        result_t [MAX_RESULTS-1:0]         res;
        logic [HELD_DEPTH-1:0][BYTE_W-1:0] held_bytes;
        logic [CNT_W-1:0]                  held_count;
    } decode_t;

    function automatic logic [LEN_W-1:0] seq_len(input logic [BYTE_W-1:0] c);
        if (c < ASCII_LIMIT)                      return LEN_ONE;
        else if ((c & MASK_LEAD2) == PAT_LEAD2)   return LEN_TWO;
        else if ((c & MASK_LEAD3) == PAT_LEAD3)   return LEN_THREE;
        else if ((c & MASK_LEAD4) == PAT_LEAD4)   return LEN_FOUR;
        else                                      return LEN_ONE;
    endfunction

    // Byte at position idx of a four-byte window; beyond the window reads zero
    function automatic logic [BYTE_W-1:0] pick_byte(input logic [BUF_W-1:0] w,
                                                    input logic [LEN_W-1:0] idx);
        return idx[2] ? '0 : w[{idx[1:0], 3'b000} +: BYTE_W];
    endfunction

    function automatic logic [CP_W-1:0] compose(input logic [BYTE_W-1:0] b0,
                                                input logic [BYTE_W-1:0] b1,
                                                input logic [BYTE_W-1:0] b2,
                                                input logic [BYTE_W-1:0] b3,
                                                input logic [LEN_W-1:0]  n);
        logic [CP_W-1:0] cp;
        unique case (n)
            LEN_TWO:   cp = {10'd0, b0[4:0], b1[5:0]};
            LEN_THREE: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
            LEN_FOUR:  cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            default:   cp = {13'd0, b0};
        endcase
        return cp;
    endfunction

endpackage

@@ sv/utf8d_if.sv @@
// Byte input and codepoint output channel interfaces.
interface utf8d_in_if;
    logic                          valid;
    logic                          ready;
    logic [utf8d_pkg::BYTE_W-1:0]  data_byte;
    logic                          final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface utf8d_out_if;
    logic                          valid;
    logic                          ready;
    logic [utf8d_pkg::CP_W-1:0]    codepoint;
    logic [utf8d_pkg::USED_W-1:0]  bytes_used;
    logic                          string_end;

    modport source (output valid, output codepoint, output bytes_used,
                    output string_end, input ready);
    modport sink   (input valid, input codepoint, input bytes_used,
                    input string_end, output ready);
endinterface

@@ sv/utf8d_decode.sv @@
// Combinational decode of one byte against the held partial sequence.
module utf8d_decode
    import utf8d_pkg::*;
(
    input  logic [HELD_DEPTH-1:0][BYTE_W-1:0] held_bytes,
    input  logic [CNT_W-1:0]                  held_count,
    input  logic [BYTE_W-1:0]                 data_byte,
    input  logic                              final_byte,
    output decode_t                           dec
);

    always_comb
    begin
        logic [BUF_W-1:0]  win;
        logic [LEN_W-1:0]  len;
        logic [LEN_W-1:0]  pos;
        logic [LEN_W-1:0]  n;
        logic [BYTE_W-1:0] b0;
        logic [CP_W-1:0]   cp;

        // Window: held bytes, lead first, then the new byte
        win = '0;
        for (int i = 0; i < HELD_DEPTH; i++)
        begin
            if (CNT_W'(i) < held_count)
            begin
                win[i*BYTE_W +: BYTE_W] = held_bytes[i];
            end
        end
        win[{held_count, 3'b000} +: BYTE_W] = data_byte;
        len = {1'b0, held_count} + LEN_ONE;

        dec            = '0;
        dec.held_bytes = held_bytes;
        dec.held_count = '0;
        pos            = '0;
        n              = LEN_ONE;
        b0             = '0;
        cp             = '0;

        if (final_byte)
        begin
            // Flush: a truncated lead goes out as itself, then re-decode the rest
            for (int s = 0; s < MAX_RESULTS; s++)
            begin
                if (pos < len)
                begin
                    b0 = pick_byte(win, pos);
                    n  = seq_len(b0);
                    if (n > len - pos)
                    begin
                        n  = LEN_ONE;
                        cp = {13'd0, b0};
                    end
                    else
                    begin
                        cp = compose(b0, pick_byte(win, pos + 3'd1),
                                     pick_byte(win, pos + 3'd2),
                                     pick_byte(win, pos + 3'd3), n);
                    end
                    pos                    = pos + n;
                    dec.res[s].codepoint   = cp;
                    dec.res[s].bytes_used  = n;
                    dec.res[s].string_end  = (pos >= len);
                    dec.count              = CNT_W'(s + 1);
                end
            end
        end
        else
        begin
            n = seq_len(win[0 +: BYTE_W]);
            if (len >= n)
            begin
                dec.res[0].codepoint  = compose(win[0 +: BYTE_W], win[8 +: BYTE_W],
                                                win[16 +: BYTE_W], win[24 +: BYTE_W], n);
                dec.res[0].bytes_used = n;
                dec.res[0].string_end = 1'b0;
                dec.count             = CNT_W'(1);
            end
            else
            begin
                // Hold the incomplete sequence
                for (int i = 0; i < HELD_DEPTH; i++)
                begin
                    dec.held_bytes[i] = win[i*BYTE_W +: BYTE_W];
                end
                dec.held_count = len[CNT_W-1:0];
            end
        end
    end

endmodule

@@ sv/utf8d_result_buf.sv @@
// Result register bank: holds up to three results and drains them one per transfer.
module utf8d_result_buf
    import utf8d_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  logic [CNT_W-1:0]           load_count,
    input  result_t [MAX_RESULTS-1:0]  load_res,
    output logic                       can_load,
    utf8d_out_if.source                out_chan
);

    result_t [MAX_RESULTS-1:0] res_reg;
    logic [CNT_W-1:0]          res_cnt_reg;
    logic [CNT_W-1:0]          res_cnt_next;
    logic [CNT_W-1:0]          res_idx_reg;
    logic [CNT_W-1:0]          res_idx_next;
    logic                      pop;
    result_t                   head;

    assign pop      = (res_cnt_reg != '0) && out_chan.ready;
    assign can_load = (res_cnt_reg == '0) || ((res_cnt_reg == CNT_W'(1)) && out_chan.ready);

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        res_idx_next = res_idx_reg;
        if (load)
        begin
            res_cnt_next = load_count;
            res_idx_next = '0;
        end
        else if (pop)
        begin
            res_cnt_next = res_cnt_reg - CNT_W'(1);
            res_idx_next = res_idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg <= '0;
            res_idx_reg <= '0;
        end
        else
        begin
            res_cnt_reg <= res_cnt_next;
            res_idx_reg <= res_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign head                = res_reg[res_idx_reg];
    assign out_chan.valid      = (res_cnt_reg != '0);
    assign out_chan.codepoint  = head.codepoint;
    assign out_chan.bytes_used = head.bytes_used;
    assign out_chan.string_end = head.string_end;

    a_window_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, res_idx_reg} + {1'b0, res_cnt_reg}) <= 3'(MAX_RESULTS))
        else $error("result window runs past the bank");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("results loaded over undelivered results");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load && (load_count != '0) |=> out_chan.valid)
        else $error("loaded results not offered");

    a_end_last_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_chan.valid && (res_cnt_reg > CNT_W'(1)) |-> !out_chan.string_end)
        else $error("string end flagged before the last result");

endmodule

@@ sv/utf8_stream_decoder.sv @@
// Lenient streaming UTF-8 decoder top level.
// A byte is registered at the input and its results in the result bank before
// they are offered. Throughput: one byte per cycle while the bank can take results;
// a final byte that yields k results holds the output for k transfers, set by the single-read result bank.
// Reset (rst_n, asynchronous, active low) empties the input register, the
// result bank and the held sequence; held bytes themselves are not cleared.
module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    utf8d_in_if.sink    in_chan,
    utf8d_out_if.source out_chan
);

    // Input register
    logic                              in_valid_reg;
    logic [BYTE_W-1:0]                 in_byte_reg;
    logic                              in_final_reg;

    // Partial sequence carried between bytes
    logic [HELD_DEPTH-1:0][BYTE_W-1:0] held_bytes_reg;
    logic [CNT_W-1:0]                  held_count_reg;

    decode_t                           dec;
    logic                              can_load;
    logic                              load;

    // Decode the registered byte against the held bytes
    utf8d_decode u_decode (
        .held_bytes (held_bytes_reg),
        .held_count (held_count_reg),
        .data_byte  (in_byte_reg),
        .final_byte (in_final_reg),
        .dec        (dec)
    );

    // Move the decoded byte on once the bank is empty or emptying this cycle;
    // bytes that only extend a sequence move on just the same with no result.
    assign load          = in_valid_reg && can_load;
    assign in_chan.ready = !in_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            held_count_reg <= '0;
        end
        else
        begin
            if (in_chan.ready)
            begin
                in_valid_reg <= in_chan.valid;
            end
            if (load)
            begin
                held_count_reg <= dec.held_count;
            end
        end
    end

    // Payload: hold unless a transfer or a decode advances it
    always_ff @(posedge clk)
    begin
        if (in_chan.ready && in_chan.valid)
        begin
            in_byte_reg  <= in_chan.data_byte;
            in_final_reg <= in_chan.final_byte;
        end
        if (load)
        begin
            held_bytes_reg <= dec.held_bytes;
        end
    end

    utf8d_result_buf u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .load_count (dec.count),
        .load_res   (dec.res),
        .can_load   (can_load),
        .out_chan   (out_chan)
    );

    // A final byte always drops the held sequence
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load && in_final_reg |=> (held_count_reg == '0))
        else $error("held bytes survive the end of a string");

    // The end of a string always yields at least one result
    a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
        load && in_final_reg |-> (dec.count != '0))
        else $error("final byte produced no result");

    // Only a lead still short of bytes is ever held
    a_held_is_short: assert property (@(posedge clk) disable iff (!rst_n)
        (held_count_reg != '0) |-> (seq_len(held_bytes_reg[0]) > {1'b0, held_count_reg}))
        else $error("held sequence already complete");

endmodule
